// ----- hw/rtl/rsem_pkg.sv -----
package rsem_pkg;

  localparam int LINE_PIXELS = 1024;
  localparam int COL_W = $clog2(LINE_PIXELS);
  localparam int WIDTH_W = COL_W + 1;
  localparam int ROW_W = 12;
  localparam int CFG_WIDTH_W = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int BANKS = 4;

  localparam logic [15:0] GRAY_R = 16'd19595;
  localparam logic [15:0] GRAY_G = 16'd38470;
  localparam logic [15:0] GRAY_B = 16'd7471;
  localparam logic [7:0] MAG_MAX = 8'd255;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic do_write;
    logic [1:0] wrow;
    logic [COL_W-1:0] wcol;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic do_out;
    logic [ROW_W-1:0] y;
    logic [COL_W-1:0] x;
    logic last;
  } task_t;

  typedef struct packed {
    logic [7:0] mag;
    logic last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_GRAD,
    ST_MULT,
    ST_SQRT,
    ST_EMIT
  } back_state_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [CFG_WIDTH_W-1:0] fw);
    logic [WIDTH_W-1:0] w;
    if (fw == '0) begin
      w = WIDTH_W'(1);
    end else if (32'(fw) > LINE_PIXELS) begin
      w = WIDTH_W'(LINE_PIXELS);
    end else begin
      w = WIDTH_W'(fw);
    end
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [CFG_HEIGHT_W-1:0] fh);
    logic [ROW_W-1:0] h;
    if (fh == '0) begin
      h = ROW_W'(1);
    end else begin
      h = ROW_W'(fh);
    end
    return h;
  endfunction

endpackage

// ----- hw/rtl/rsem_queue.sv -----
module rsem_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  rsem_pkg::task_t din,
  output logic q_full,
  input  logic rd,
  output rsem_pkg::task_t dout,
  output logic q_empty
);

  rsem_pkg::task_t slots [rsem_pkg::QUEUE_DEPTH];
  logic [rsem_pkg::QUEUE_PTR_W-1:0] wp;
  logic [rsem_pkg::QUEUE_PTR_W-1:0] rp;
  logic [rsem_pkg::QUEUE_PTR_W:0] count;

  assign q_full = (32'(count) == rsem_pkg::QUEUE_DEPTH);
  assign q_empty = (count == '0);
  assign dout = slots[rp];

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr && !q_full) begin
        wp <= wp + 1'b1;
      end
      if (rd && !q_empty) begin
        rp <= rp + 1'b1;
      end
      count <= count + (rsem_pkg::QUEUE_PTR_W+1)'(wr && !q_full)
                     - (rsem_pkg::QUEUE_PTR_W+1)'(rd && !q_empty);
    end
  end

endmodule

// ----- hw/rtl/rsem_front.sv -----
module rsem_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic cmd,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [rsem_pkg::CFG_WIDTH_W-1:0] frame_width,
  input  logic [rsem_pkg::CFG_HEIGHT_W-1:0] frame_height,
  input  logic q_full,
  output logic full,
  output logic q_wr,
  output rsem_pkg::task_t q_din
);

  logic [rsem_pkg::COL_W-1:0] in_col, in_col_next;
  logic [rsem_pkg::ROW_W-1:0] in_row, in_row_next;
  logic [rsem_pkg::COL_W-1:0] out_col, out_col_next;
  logic [rsem_pkg::ROW_W-1:0] out_row, out_row_next;
  logic [rsem_pkg::WIDTH_W-1:0] lead, lead_next;

  logic [rsem_pkg::WIDTH_W-1:0] w;
  logic [rsem_pkg::ROW_W-1:0] h;
  logic accept, in_frame, skip, lead_done;
  logic [rsem_pkg::WIDTH_W-1:0] col_inc, ocol_inc;
  logic [rsem_pkg::ROW_W:0] orow_inc;

  assign full = q_full;
  assign accept = push && !q_full;

  always_comb begin
    w = rsem_pkg::eff_width(frame_width);
    h = rsem_pkg::eff_height(frame_height);
    in_frame = (in_row < h);
    skip = in_frame && (cmd == rsem_pkg::CMD_DRAIN);
    lead_done = ({1'b0, lead} >= ({1'b0, w} + 1'b1));
    col_inc = {1'b0, in_col} + 1'b1;
    ocol_inc = {1'b0, out_col} + 1'b1;
    orow_inc = {1'b0, out_row} + 1'b1;

    in_col_next = in_col;
    in_row_next = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    lead_next = lead;

    q_din.do_write = in_frame && (cmd == rsem_pkg::CMD_PIXEL);
    q_din.wrow = in_row[1:0];
    q_din.wcol = in_col;
    q_din.red = red;
    q_din.green = green;
    q_din.blue = blue;
    q_din.do_out = !skip && lead_done;
    q_din.y = out_row;
    q_din.x = out_col;
    q_din.last = (orow_inc >= {1'b0, h}) && (ocol_inc >= w);

    if (q_din.do_write) begin
      if (col_inc >= w) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = col_inc[rsem_pkg::COL_W-1:0];
      end
    end

    if (!skip) begin
      if (!lead_done) begin
        lead_next = lead + 1'b1;
      end else if (q_din.last) begin
        in_col_next = '0;
        in_row_next = '0;
        out_col_next = '0;
        out_row_next = '0;
        lead_next = '0;
      end else if (ocol_inc >= w) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = ocol_inc[rsem_pkg::COL_W-1:0];
      end
    end

    q_wr = accept && (q_din.do_write || q_din.do_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
      out_col <= '0;
      out_row <= '0;
      lead <= '0;
    end else if (accept) begin
      in_col <= in_col_next;
      in_row <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      lead <= lead_next;
    end
  end

endmodule

// ----- hw/rtl/rsem_back.sv -----
module rsem_back (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  rsem_pkg::task_t q_dout,
  output logic q_rd,
  input  logic [rsem_pkg::CFG_WIDTH_W-1:0] frame_width,
  input  logic [rsem_pkg::CFG_HEIGHT_W-1:0] frame_height,
  input  logic pop,
  output logic empty,
  output logic [7:0] edge_strength,
  output logic frame_end
);

  rsem_pkg::back_state_t state, state_next;
  rsem_pkg::task_t job;
  logic [1:0] k;
  logic [2:0] iter;
  logic [7:0] p [3][3];
  logic [7:0] rd_data [rsem_pkg::BANKS];
  logic signed [10:0] gx, gy;
  logic [15:0] v, r;
  logic sat;

  logic [rsem_pkg::WIDTH_W-1:0] w;
  logic [rsem_pkg::ROW_W-1:0] h;
  logic [rsem_pkg::COL_W-1:0] xx, raddr, wmax;
  logic [rsem_pkg::ROW_W-1:0] yy, hmax;
  logic [rsem_pkg::ROW_W-1:0] rows [3];
  logic [23:0] gray_sum;
  logic [15:0] bitv;
  logic [16:0] trial;
  logic wr_en, push_res;
  logic signed [21:0] sqx, sqy;
  logic [21:0] sum;

  rsem_pkg::result_t ofifo [2];
  logic owp, orp;
  logic [1:0] ocnt;
  logic ofull;

  assign empty = (ocnt == 2'd0);
  assign ofull = (ocnt == 2'd2);
  assign edge_strength = ofifo[orp].mag;
  assign frame_end = ofifo[orp].last;

  always_comb begin
    w = rsem_pkg::eff_width(frame_width);
    h = rsem_pkg::eff_height(frame_height);
    wmax = rsem_pkg::COL_W'(w - 1'b1);
    hmax = h - 1'b1;
    xx = (rsem_pkg::WIDTH_W'(job.x) > rsem_pkg::WIDTH_W'(wmax)) ? wmax : job.x;
    yy = (job.y > hmax) ? hmax : job.y;
    rows[0] = (yy == '0) ? '0 : yy - 1'b1;
    rows[1] = yy;
    rows[2] = ({1'b0, yy} + 1'b1 > {1'b0, hmax}) ? hmax : yy + 1'b1;
    case (k)
      2'd0: raddr = (xx == '0) ? '0 : xx - 1'b1;
      2'd2: raddr = ({1'b0, xx} + 1'b1 > {1'b0, wmax}) ? wmax : xx + 1'b1;
      default: raddr = xx;
    endcase
    gray_sum = 24'(rsem_pkg::GRAY_R) * 24'(job.red) + 24'(rsem_pkg::GRAY_G) * 24'(job.green)
             + 24'(rsem_pkg::GRAY_B) * 24'(job.blue);
    bitv = 16'h4000 >> {iter, 1'b0};
    trial = {1'b0, r} + {1'b0, bitv};
    sqx = gx * gx;
    sqy = gy * gy;
    sum = 22'(sqx[20:0]) + 22'(sqy[20:0]);
  end

  always_comb begin
    state_next = state;
    q_rd = 1'b0;
    wr_en = 1'b0;
    push_res = 1'b0;
    case (state)
      rsem_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          if (q_dout.do_write) begin
            state_next = rsem_pkg::ST_WRITE;
          end else if (q_dout.do_out) begin
            state_next = rsem_pkg::ST_READ;
          end
        end
      end
      rsem_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        state_next = job.do_out ? rsem_pkg::ST_READ : rsem_pkg::ST_IDLE;
      end
      rsem_pkg::ST_READ: begin
        if (k == 2'd3) begin
          state_next = rsem_pkg::ST_GRAD;
        end
      end
      rsem_pkg::ST_GRAD: state_next = rsem_pkg::ST_MULT;
      rsem_pkg::ST_MULT: state_next = rsem_pkg::ST_SQRT;
      rsem_pkg::ST_SQRT: begin
        if (iter == 3'd7) begin
          state_next = rsem_pkg::ST_EMIT;
        end
      end
      rsem_pkg::ST_EMIT: begin
        if (!ofull) begin
          push_res = 1'b1;
          state_next = rsem_pkg::ST_IDLE;
        end
      end
      default: state_next = rsem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  for (genvar b = 0; b < rsem_pkg::BANKS; b++) begin : g_bank
    logic [7:0] mem [rsem_pkg::LINE_PIXELS];
    always_ff @(posedge clk) begin
      if (wr_en && (32'(job.wrow) == b)) begin
        mem[job.wcol] <= gray_sum[23:16];
      end
      rd_data[b] <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      job <= q_dout;
    end
    if (state == rsem_pkg::ST_READ) begin
      k <= k + 1'b1;
      if (k != 2'd0) begin
        for (int dy = 0; dy < 3; dy++) begin
          p[dy][k - 2'd1] <= rd_data[rows[dy][1:0]];
        end
      end
    end else begin
      k <= 2'd0;
    end
    if (state == rsem_pkg::ST_GRAD) begin
      gx <= (11'(p[0][2]) - 11'(p[0][0])) + ((11'(p[1][2]) - 11'(p[1][0])) <<< 1)
          + (11'(p[2][2]) - 11'(p[2][0]));
      gy <= (11'(p[2][0]) - 11'(p[0][0])) + ((11'(p[2][1]) - 11'(p[0][1])) <<< 1)
          + (11'(p[2][2]) - 11'(p[0][2]));
    end
    if (state == rsem_pkg::ST_MULT) begin
      v <= sum[15:0];
      sat <= |sum[21:16];
      r <= '0;
      iter <= 3'd0;
    end
    if (state == rsem_pkg::ST_SQRT) begin
      iter <= iter + 1'b1;
      if ({1'b0, v} >= trial) begin
        v <= v - trial[15:0];
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
    end
    if (push_res) begin
      ofifo[owp].mag <= sat ? rsem_pkg::MAG_MAX : r[7:0];
      ofifo[owp].last <= job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= 1'b0;
      orp <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (push_res) begin
        owp <= ~owp;
      end
      if (pop && !empty) begin
        orp <= ~orp;
      end
      ocnt <= ocnt + 2'(push_res) - 2'(pop && !empty);
    end
  end

endmodule

// ----- hw/rtl/rgb_sobel_edge_magnitude.sv -----
// Sobel edge magnitude on an RGB pixel stream in raster order.
// Input words arrive through push/full; cmd selects a pixel or a drain word.
// Each pixel is turned into gray and stored in four line banks; results
// come out in raster order through empty/pop, the oldest on the ports while
// empty is low. The first result of a frame follows the word after the first
// frame_width+1 words, and frame_width+1 drain words flush the rest; the last
// result carries frame_end.
// A front stage tracks the frame counters and queues up to four words for
// the back stage, which runs one word at a time: a pixel write, and for a
// result the read state over three columns, gradient, square, eight square
// root steps and an emit state. A new word leaves the queue only once the
// back stage is idle again. It stalls only when both result slots are full
// and pop stays low; the queue then fills and full rises.
// Reset clears all counters and queues; the line banks are not cleared.
// Registers frame_width (address 0) and frame_height (address 4) are written over
// the APB port; the user must write them only while the block is idle, which it does not enforce.
module rgb_sobel_edge_magnitude (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic cmd,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic empty,
  input  logic pop,
  output logic [7:0] edge_strength,
  output logic frame_end,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [rsem_pkg::CFG_WIDTH_W-1:0] frame_width;
  logic [rsem_pkg::CFG_HEIGHT_W-1:0] frame_height;
  logic q_full, q_empty, q_wr, q_rd;
  rsem_pkg::task_t q_din, q_dout;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      rsem_pkg::REG_FRAME_WIDTH: prdata = 32'(frame_width);
      rsem_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= rsem_pkg::CFG_WIDTH_W'(640);
      frame_height <= rsem_pkg::CFG_HEIGHT_W'(480);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == rsem_pkg::REG_FRAME_WIDTH) begin
        frame_width <= pwdata[rsem_pkg::CFG_WIDTH_W-1:0];
      end else begin
        frame_height <= pwdata[rsem_pkg::CFG_HEIGHT_W-1:0];
      end
    end
  end

  rsem_front u_front (
    .clk(clk), .rst(rst), .push(push), .cmd(cmd), .red(red), .green(green),
    .blue(blue), .frame_width(frame_width), .frame_height(frame_height),
    .q_full(q_full), .full(full), .q_wr(q_wr), .q_din(q_din)
  );

  rsem_queue u_queue (
    .clk(clk), .rst(rst), .wr(q_wr), .din(q_din), .q_full(q_full),
    .rd(q_rd), .dout(q_dout), .q_empty(q_empty)
  );

  rsem_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_dout(q_dout), .q_rd(q_rd),
    .frame_width(frame_width), .frame_height(frame_height), .pop(pop),
    .empty(empty), .edge_strength(edge_strength), .frame_end(frame_end)
  );

  assert property (@(posedge clk) rst |=> !full)
    else $error("input side full right after reset");
  assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");
  assert property (@(posedge clk) disable iff (rst) q_rd |-> !q_empty)
    else $error("back stage took a word from an empty queue");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import rsem_pkg::*;

  typedef struct packed {
    logic cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_word_t;

  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic cmd = CMD_PIXEL;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] edge_strength;
  logic frame_end;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rgb_sobel_edge_magnitude i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .red(red),
    .green(green), .blue(blue), .empty(empty), .pop(pop),
    .edge_strength(edge_strength), .frame_end(frame_end), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  pixel_word_t pixel_q[$];
  result_t edge_q[$];
  pixel_word_t held_word;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  logic [CFG_WIDTH_W-1:0] width_reg = CFG_WIDTH_W'(640);
  logic [CFG_HEIGHT_W-1:0] height_reg = CFG_HEIGHT_W'(480);
  logic [7:0] gray_store[4][LINE_PIXELS];
  int in_col = 0, in_row = 0, out_col = 0, out_row = 0, lead = 0;

  function automatic int root_floor(int v);
    int r, b;
    r = 0;
    b = 1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int gray_read(int r, int c, int w, int h);
    if (r < 0) r = 0;
    if (r > h - 1) r = h - 1;
    if (c < 0) c = 0;
    if (c > w - 1) c = w - 1;
    return int'(gray_store[r & 3][c]);
  endfunction

  function automatic void edge_predict(pixel_word_t wd);
    int w, h, g, col, y, x, gx, gy, sum;
    int p[3][3];
    result_t res;
    w = (width_reg == 0) ? 1 : ((int'(width_reg) > LINE_PIXELS) ? LINE_PIXELS
        : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    if (in_row < h) begin
      if (wd.cmd == CMD_DRAIN) return;
      g = (19595 * wd.red + 38470 * wd.green + 7471 * wd.blue) >> 16;
      col = (in_col > LINE_PIXELS - 1) ? LINE_PIXELS - 1 : in_col;
      gray_store[in_row & 3][col] = g[7:0];
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (lead < w + 1) begin
      lead++;
      return;
    end
    y = (out_row > h - 1) ? h - 1 : out_row;
    x = (out_col > w - 1) ? w - 1 : out_col;
    for (int dy = 0; dy < 3; dy++)
      for (int dx = 0; dx < 3; dx++)
        p[dy][dx] = gray_read(y + dy - 1, x + dx - 1, w, h);
    gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
    gy = (p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
    sum = gx * gx + gy * gy;
    res.mag = (sum >= 65536) ? MAG_MAX : 8'(root_floor(sum));
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (res.last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      lead = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    edge_q.push_back(res);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) edge_predict(held_word);
      if (!push || !full) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_word = pixel_q.pop_front();
          push <= 1'b1;
          cmd <= held_word.cmd;
          red <= held_word.red;
          green <= held_word.green;
          blue <= held_word.blue;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (edge_q.size() == 0) begin
          report_mismatch("unexpected word", edge_strength, -1);
        end else begin
          if (edge_strength !== edge_q[0].mag)
            report_mismatch("edge_strength", edge_strength, edge_q[0].mag);
          if (frame_end !== edge_q[0].last)
            report_mismatch("frame_end", frame_end, edge_q[0].last);
          void'(edge_q.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(logic reg_index, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_index == REG_FRAME_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
    else height_reg = value[CFG_HEIGHT_W-1:0];
  endtask

  function automatic logic [7:0] channel_value();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_word_t make_pixel(logic is_drain);
    pixel_word_t wd;
    wd.cmd = is_drain ? CMD_DRAIN : CMD_PIXEL;
    wd.red = channel_value();
    wd.green = channel_value();
    wd.blue = channel_value();
    return wd;
  endfunction

  task automatic run_frame(int wreg, int hreg, int mode, output int words);
    int w, h;
    pixel_word_t wd;
    case (mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 52; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 52; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
    if ($urandom_range(1)) begin
      reg_write(REG_FRAME_WIDTH, 32'(wreg));
      reg_write(REG_FRAME_HEIGHT, 32'(hreg));
    end else begin
      reg_write(REG_FRAME_HEIGHT, 32'(hreg));
      reg_write(REG_FRAME_WIDTH, 32'(wreg));
    end
    w = (wreg == 0) ? 1 : ((wreg > LINE_PIXELS) ? LINE_PIXELS : wreg);
    h = (hreg == 0) ? 1 : hreg;
    words = 0;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(19) == 0) pixel_q.push_back(make_pixel(1'b1));
      wd = make_pixel(1'b0);
      if (w == 3 && h == 3) begin
        wd.red = (i / 3 == 1) ? 8'd255 : 8'd0;
        wd.green = wd.red;
        wd.blue = wd.red;
      end
      pixel_q.push_back(wd);
      words++;
    end
    for (int i = 0; i <= w; i++) begin
      pixel_q.push_back(make_pixel($urandom_range(4) != 0));
      words++;
    end
    while (pixel_q.size() > 0 || push || edge_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int mode, total, words;
    mode = 0;
    total = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    run_frame(3, 3, mode++, words);
    total += words;
    run_frame(0, 0, mode++, words);
    total += words;
    run_frame(1, 1, mode++, words);
    total += words;
    run_frame(4, 5, mode++, words);
    total += words;
    run_frame(70, 2, mode++, words);
    total += words;
    run_frame(1, 120, mode++, words);
    total += words;
    run_frame(7, 0, mode++, words);
    total += words;
    while (total < 1850) begin
      if ($urandom_range(9) == 0)
        run_frame($urandom_range(9, 40), $urandom_range(1, 4), mode++, words);
      else
        run_frame($urandom_range(1, 8), $urandom_range(1, 6), mode++, words);
      total += words;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
